/* design/vlpd_pkg.sv */
// ----------------------------------------------------------------------------
// Varint length-prefix deframer package
// Shared constants and types for the deframer modules.
// ----------------------------------------------------------------------------
package vlpd_pkg;

	localparam int unsigned MAX_PREFIX_BYTES = 10;
	localparam int unsigned LEN_W            = 64;
	localparam int unsigned DIGIT_BITS       = 7;
	localparam int unsigned CNT_W            = $clog2(MAX_PREFIX_BYTES + 1);
	localparam int unsigned SHAMT_W          = $clog2(DIGIT_BITS * MAX_PREFIX_BYTES + 1);

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_of_packet;
		logic       empty_packet;
		logic       prefix_error;
	} result_t;

	typedef struct packed {
		logic             in_payload;
		logic [CNT_W-1:0] prefix_count;
		logic             remaining_zero;
	} parse_status_t;

endpackage

/* design/varint_length_prefix_deframer.sv */
// ----------------------------------------------------------------------------
// Varint length-prefix deframer
// Splits a byte stream into packets framed by base-128 varint lengths.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, data_byte) takes one stream byte per
// transaction. Each packet is its little-endian varint length followed by
// that many payload bytes. The output channel (out_valid, out_ready and the
// result fields) gives one transaction per payload byte, with last_of_packet
// on the final byte, one empty_packet transaction for a zero length, and one
// prefix_error transaction when a prefix runs past its maximum byte count.
// Prefix bytes otherwise produce no transaction.
// A byte passes an input register and then the parser, and its result is
// registered in the result register.
// The block takes one byte per cycle while the receiver keeps up; that rate
// is set by the single parser stage between the two registers.
// When the receiver stalls, the result register holds, the input register
// takes one more byte only if it is empty, and in_ready stays low until the
// result register frees.
// Reset clears the framing state so that the first byte begins a prefix,
// and empties both registers.
// ----------------------------------------------------------------------------
module varint_length_prefix_deframer import vlpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       last_of_packet,
	output logic       empty_packet,
	output logic       prefix_error
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          free;
	logic          fire;
	logic          res_valid;
	result_t       res;
	result_t       res_q;
	parse_status_t status;

	assign fire = valid_s1 && free;

	vlpd_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.advance   (free),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	vlpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res),
		.status    (status)
	);

	vlpd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign payload_byte   = res_q.payload_byte;
	assign last_of_packet = res_q.last_of_packet;
	assign empty_packet   = res_q.empty_packet;
	assign prefix_error   = res_q.prefix_error;

`ifndef SYNTHESIS
	a_payload_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		status.in_payload |-> !status.remaining_zero)
		else $error("Payload state entered with no bytes remaining.");

	a_prefix_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.prefix_count < CNT_W'(MAX_PREFIX_BYTES))
		else $error("Prefix byte count passed its limit.");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prefix_error |-> !last_of_packet && !empty_packet
			&& payload_byte == 8'd0)
		else $error("Error result carries packet data.");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_packet |-> last_of_packet && payload_byte == 8'd0)
		else $error("Empty packet result is malformed.");
`endif

endmodule

/* design/vlpd_in_reg.sv */
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted stream byte until the parser stage consumes it.
// ----------------------------------------------------------------------------
module vlpd_in_reg import vlpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

/* design/vlpd_parser.sv */
// ----------------------------------------------------------------------------
// Prefix and payload parser
// Keeps the framing state and forms at most one result per consumed byte.
// ----------------------------------------------------------------------------
module vlpd_parser import vlpd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    byte_s1,
	output logic          res_valid,
	output result_t       res,
	output parse_status_t status
);

	logic             in_payload_q;
	logic [LEN_W-1:0] length_accum_q;
	logic [CNT_W-1:0] prefix_count_q;
	logic [LEN_W-1:0] bytes_remaining_q;

	logic [SHAMT_W-1:0] shamt;
	logic [LEN_W-1:0]   accum_nxt;
	logic [CNT_W-1:0]   count_inc;
	logic               more;
	logic               overlong;
	logic [LEN_W-1:0]   remaining_dec;
	logic               payload_last;

	always_comb begin
		shamt         = SHAMT_W'(prefix_count_q) * SHAMT_W'(DIGIT_BITS);
		accum_nxt     = length_accum_q | (LEN_W'(byte_s1[DIGIT_BITS-1:0]) << shamt);
		count_inc     = prefix_count_q + CNT_W'(1);
		more          = byte_s1[7];
		overlong      = more && (count_inc >= CNT_W'(MAX_PREFIX_BYTES));
		remaining_dec = (bytes_remaining_q != '0) ? bytes_remaining_q - LEN_W'(1)
			: bytes_remaining_q;
		payload_last  = (remaining_dec == '0);
	end

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (in_payload_q) begin
			res_valid          = 1'b1;
			res.payload_byte   = byte_s1;
			res.last_of_packet = payload_last;
		end else if (overlong) begin
			res_valid        = 1'b1;
			res.prefix_error = 1'b1;
		end else if (!more && accum_nxt == '0) begin
			res_valid          = 1'b1;
			res.last_of_packet = 1'b1;
			res.empty_packet   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q      <= 1'b0;
			length_accum_q    <= '0;
			prefix_count_q    <= '0;
			bytes_remaining_q <= '0;
		end else if (fire) begin
			if (in_payload_q) begin
				bytes_remaining_q <= remaining_dec;
				if (payload_last) begin
					in_payload_q   <= 1'b0;
					length_accum_q <= '0;
					prefix_count_q <= '0;
				end
			end else if (more) begin
				if (overlong) begin
					length_accum_q <= '0;
					prefix_count_q <= '0;
				end else begin
					length_accum_q <= accum_nxt;
					prefix_count_q <= count_inc;
				end
			end else begin
				length_accum_q <= '0;
				prefix_count_q <= '0;
				if (accum_nxt != '0) begin
					bytes_remaining_q <= accum_nxt;
					in_payload_q      <= 1'b1;
				end
			end
		end
	end

	assign status.in_payload     = in_payload_q;
	assign status.prefix_count   = prefix_count_q;
	assign status.remaining_zero = (bytes_remaining_q == '0);

endmodule

/* design/vlpd_out_reg.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module vlpd_out_reg import vlpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_q
);

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule
